// File: hdl/drm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package drm_pkg;

	localparam int LANES_DEF    = 4;
	localparam int SAMPLE_W_DEF = 24;

	localparam int THR_W   = 20;
	localparam int KNEE_W  = 21;
	localparam int SCALE_W = 29;
	localparam int GAIN_W  = 24;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	localparam int NSTG   = 7;
	localparam int D_BITS = 22;
	localparam int SQ_W   = 2 * D_BITS;
	localparam int PROD_W = SQ_W - D_BITS + SCALE_W;
	localparam int CRV_W  = 32;
	localparam int LO_W   = 18;

	localparam logic [THR_W-1:0]   THR_RST   = 20'd0;
	localparam logic [KNEE_W-1:0]  KNEE_RST  = 21'h100000;
	localparam logic [SCALE_W-1:0] SCALE_RST = 29'h0080000;
	localparam logic [GAIN_W-1:0]  GAIN_RST  = 24'h100000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 4'd0,
		REG_KNEE      = 4'd1,
		REG_SCALE     = 4'd2,
		REG_GAIN      = 4'd3
	} drm_reg_t;

	typedef struct packed {
		logic [THR_W-1:0]   thr;
		logic [KNEE_W-1:0]  knee;
		logic [SCALE_W-1:0] scale;
		logic [GAIN_W-1:0]  gain;
	} drm_cfg_t;

	function automatic int term_w(input int w);
		return (w + 3 > 34) ? w + 3 : 34;
	endfunction

endpackage

`default_nettype wire

// File: hdl/drm_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface drm_smp_if #(
	parameter int LANES        = 4,
	parameter int SAMPLE_WIDTH = 24
);
	logic                          valid;
	logic                          ready;
	logic [LANES*SAMPLE_WIDTH-1:0] carrier;
	logic [LANES*SAMPLE_WIDTH-1:0] modulator;

	modport source (output valid, output carrier, output modulator, input ready);
	modport sink (input valid, input carrier, input modulator, output ready);
endinterface

interface drm_mix_if #(
	parameter int LANES        = 4,
	parameter int SAMPLE_WIDTH = 24
);
	logic                          valid;
	logic                          ready;
	logic [LANES*SAMPLE_WIDTH-1:0] mixed;

	modport source (output valid, output mixed, input ready);
	modport sink (input valid, input mixed, output ready);
endinterface

interface drm_cfg_if;
	import drm_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/drm_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module drm_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	drm_cfg_if.sink           cfg,
	output drm_pkg::drm_cfg_t regs
);
	import drm_pkg::*;

	drm_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.thr   <= THR_RST;
			regs_q.knee  <= KNEE_RST;
			regs_q.scale <= SCALE_RST;
			regs_q.gain  <= GAIN_RST;
		end else if (cfg.valid) begin
			unique case (drm_reg_t'(cfg.index))
				REG_THRESHOLD: regs_q.thr   <= cfg.data[THR_W-1:0];
				REG_KNEE:      regs_q.knee  <= cfg.data[KNEE_W-1:0];
				REG_SCALE:     regs_q.scale <= cfg.data[SCALE_W-1:0];
				REG_GAIN:      regs_q.gain  <= cfg.data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/drm_diode.sv
`timescale 1ns / 1ps
`default_nettype none

module drm_diode #(
	parameter int SAMPLE_WIDTH = drm_pkg::SAMPLE_W_DEF
) (
	input  logic                                           clk,
	input  logic [drm_pkg::NSTG-1:0]                       adv,
	input  drm_pkg::drm_cfg_t                              regs,
	input  logic signed [SAMPLE_WIDTH+1:0]                 v,
	output logic signed [drm_pkg::term_w(SAMPLE_WIDTH)-1:0] term
);
	import drm_pkg::*;

	localparam int D_W = term_w(SAMPLE_WIDTH);

	logic signed [D_W-1:0] vx;
	logic signed [D_W-1:0] k2;
	logic signed [D_W-1:0] t2;
	logic signed [D_W-1:0] lin;
	logic [D_W-1:0]        dfull;

	logic signed [D_W-1:0] lin_s1, lin_s2, lin_s3;
	logic                  sel_lin_s1, sel_lin_s2, sel_lin_s3;
	logic                  sel_crv_s1, sel_crv_s2, sel_crv_s3;
	logic [D_BITS-1:0]     d_s1;
	logic [SQ_W-1:0]       sq_s2;
	logic [PROD_W-1:0]     ph_s3, pl_s3;
	logic [PROD_W-1:0]     acc;
	logic signed [D_W-1:0] term_s4;

	always_comb begin
		vx    = D_W'(v);
		k2    = $signed({{(D_W-KNEE_W-1){1'b0}}, regs.knee, 1'b0});
		t2    = $signed({{(D_W-THR_W-1){1'b0}}, regs.thr, 1'b0});
		lin   = vx - $signed(D_W'(regs.knee)) - $signed(D_W'(regs.thr));
		dfull = vx - t2;
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			lin_s1     <= lin;
			sel_lin_s1 <= vx > k2;
			sel_crv_s1 <= vx > t2;
			d_s1       <= dfull[D_BITS-1:0];
		end
		if (adv[1]) begin
			lin_s2     <= lin_s1;
			sel_lin_s2 <= sel_lin_s1;
			sel_crv_s2 <= sel_crv_s1;
			sq_s2      <= d_s1 * d_s1;
		end
		if (adv[2]) begin
			lin_s3     <= lin_s2;
			sel_lin_s3 <= sel_lin_s2;
			sel_crv_s3 <= sel_crv_s2;
			ph_s3      <= sq_s2[SQ_W-1:D_BITS] * regs.scale;
			pl_s3      <= sq_s2[D_BITS-1:0] * regs.scale;
		end
		if (adv[3]) begin
			priority if (sel_lin_s3)
				term_s4 <= lin_s3;
			else if (sel_crv_s3)
				term_s4 <= $signed(D_W'(acc[PROD_W-1:PROD_W-CRV_W]));
			else
				term_s4 <= '0;
		end
	end

	assign acc  = ph_s3 + PROD_W'(pl_s3[PROD_W-1:D_BITS]);
	assign term = term_s4;

endmodule

`default_nettype wire

// File: hdl/drm_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module drm_lane #(
	parameter int SAMPLE_WIDTH = drm_pkg::SAMPLE_W_DEF
) (
	input  logic                           clk,
	input  logic [drm_pkg::NSTG-1:0]       adv,
	input  drm_pkg::drm_cfg_t              regs,
	input  logic signed [SAMPLE_WIDTH-1:0] x,
	input  logic signed [SAMPLE_WIDTH-1:0] y,
	output logic [SAMPLE_WIDTH-1:0]        mixed
);
	import drm_pkg::*;

	localparam int V_W   = SAMPLE_WIDTH + 2;
	localparam int D_W   = term_w(SAMPLE_WIDTH);
	localparam int SUM_W = D_W + 2;
	localparam int HI_W  = SUM_W - LO_W;
	localparam int PH_W  = HI_W + GAIN_W + 1;
	localparam int PL_W  = LO_W + GAIN_W;
	localparam int P_W   = SUM_W + GAIN_W + 1;
	localparam int RW    = P_W - 21;
	localparam logic [P_W-1:0] RND = {{(P_W-21){1'b0}}, 1'b1, 20'd0};

	logic signed [V_W-1:0]   a, b;
	logic signed [V_W-1:0]   vin [4];
	logic signed [D_W-1:0]   t   [4];
	logic signed [SUM_W-1:0] sum_s5;
	logic signed [PH_W-1:0]  ph_s6;
	logic [PL_W-1:0]         pl_s6;
	logic [P_W-1:0]          prod;
	logic [RW-1:0]           res;
	logic [RW-SAMPLE_WIDTH:0] res_hi;

	always_comb begin
		a      = (V_W'(y) <<< 1) + V_W'(x);
		b      = (V_W'(y) <<< 1) - V_W'(x);
		vin[0] = a;
		vin[1] = -a;
		vin[2] = b;
		vin[3] = -b;
	end

	for (genvar g = 0; g < 4; g++) begin : g_term
		drm_diode #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_diode (
			.clk  (clk),
			.adv  (adv),
			.regs (regs),
			.v    (vin[g]),
			.term (t[g])
		);
	end

	always_ff @(posedge clk) begin
		if (adv[4])
			sum_s5 <= SUM_W'(t[0]) + SUM_W'(t[1]) - SUM_W'(t[2]) - SUM_W'(t[3]);
		if (adv[5]) begin
			ph_s6 <= $signed(sum_s5[SUM_W-1:LO_W]) * $signed({1'b0, regs.gain});
			pl_s6 <= sum_s5[LO_W-1:0] * regs.gain;
		end
	end

	always_comb begin
		prod   = {ph_s6, {LO_W{1'b0}}} + {{(P_W-PL_W){1'b0}}, pl_s6} + RND;
		res    = prod[P_W-1:21];
		res_hi = res[RW-1:SAMPLE_WIDTH-1];
		priority if (&res_hi || ~|res_hi)
			mixed = res[SAMPLE_WIDTH-1:0];
		else if (res[RW-1])
			mixed = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		else
			mixed = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	end

endmodule

`default_nettype wire

// File: hdl/diode_ring_modulator_core.sv
// Diode ring modulator, one carrier and one modulator sample per voice lane.
// Channels: samples (sink) carries carrier and modulator, packed lane 0 in
// the low bits; result (source) carries mixed in the same packing; cfg
// (sink) writes threshold, knee, curve scale and makeup gain by index.
// cfg.ready is always high; write registers only while no request is in
// flight.
// Pipeline: an accepted request reaches the result channel through seven
// register stages: the first stage forms the diode drive, then the squarer,
// the curve-scale products, the branch select, the four-term sum, the gain
// products, and the rounding, saturation and lane merge into the output
// register.
// Throughput: one request per cycle while result is not stalled; all lanes
// run in parallel, each with four diode pipelines.
// Stall: every stage advances when it is empty or the next one advances, so
// bubbles collapse while result is held; samples.ready drops only when all
// seven stages hold data and result.ready is low. Result data holds while
// stalled.
// Reset: arst_n clears the pipeline valid bits and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module diode_ring_modulator_core #(
	parameter int LANES        = drm_pkg::LANES_DEF,
	parameter int SAMPLE_WIDTH = drm_pkg::SAMPLE_W_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	drm_smp_if.sink    samples,
	drm_mix_if.source  result,
	drm_cfg_if.sink    cfg
);
	import drm_pkg::*;

	drm_cfg_t                      regs;
	logic [NSTG-1:0]               vld_q;
	logic [NSTG-1:0]               adv;
	logic [LANES*SAMPLE_WIDTH-1:0] lane_mix;
	logic [LANES*SAMPLE_WIDTH-1:0] mixed_s7;

	drm_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	always_comb begin
		adv[NSTG-1] = !vld_q[NSTG-1] || result.ready;
		for (int i = NSTG - 2; i >= 0; i--)
			adv[i] = !vld_q[i] || adv[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0])
				vld_q[0] <= samples.valid;
			for (int i = 1; i < NSTG; i++)
				if (adv[i])
					vld_q[i] <= vld_q[i-1];
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		drm_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane (
			.clk   (clk),
			.adv   (adv),
			.regs  (regs),
			.x     ($signed(samples.carrier[l*SAMPLE_WIDTH +: SAMPLE_WIDTH])),
			.y     ($signed(samples.modulator[l*SAMPLE_WIDTH +: SAMPLE_WIDTH])),
			.mixed (lane_mix[l*SAMPLE_WIDTH +: SAMPLE_WIDTH])
		);
	end

	// merge lanes into the output register
	always_ff @(posedge clk) begin
		if (adv[NSTG-1])
			mixed_s7 <= lane_mix;
	end

	assign samples.ready = adv[0];
	assign result.valid  = vld_q[NSTG-1];
	assign result.mixed  = mixed_s7;

`ifndef SYNTH
	a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q && !result.ready) |-> !samples.ready)
		else $error("input accepted with full pipeline and stalled output");

	a_hold_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		((~adv & ~vld_q) == '0))
		else $error("empty stage held");

	a_accept_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> vld_q[0])
		else $error("accepted request lost at first stage");

	a_last_stage_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NSTG-2] && adv[NSTG-1]) |=> result.valid)
		else $error("request lost before output");
`endif

endmodule

`default_nettype wire

// File: tb/sv/diode_ring_modulator_core_chk.sv
`timescale 1ns / 1ps

module diode_ring_modulator_core_chk
	import drm_pkg::*;
#(
	parameter int LANES        = LANES_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) (
	input  logic clk,
	input  logic arst_n,
	drm_smp_if   smp,
	drm_mix_if   mix,
	drm_cfg_if   cfg,
	output int   errors,
	output int   pending,
	output int   checked,
	output int   clipped
);

	localparam int W = LANES * SAMPLE_WIDTH;
	localparam longint MAX_OUT = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
	localparam longint MIN_OUT = -MAX_OUT - 1;
	localparam longint unsigned LO_MASK = (64'd1 << 22) - 64'd1;
	localparam int PRINT_CAP = 40;

	logic [THR_W-1:0]   thr_r;
	logic [KNEE_W-1:0]  knee_r;
	logic [SCALE_W-1:0] scale_r;
	logic [GAIN_W-1:0]  gain_r;

	logic [W-1:0] mix_due[$];

	// Diode current for a drive level in Q.21; linear branch wins over the curve.
	function automatic longint diode_term(input longint v);
		longint t2, k2, d;
		longint unsigned sq, acc;
		t2 = 2 * longint'(thr_r);
		k2 = 2 * longint'(knee_r);
		if (v > k2)
			return v - k2 + (longint'(knee_r) - longint'(thr_r));
		if (v > t2) begin
			d = v - t2;
			sq = longint'(d * d);
			acc = (sq >> 22) * longint'(scale_r) + (((sq & LO_MASK) * longint'(scale_r)) >> 22);
			return longint'(acc >> 19);
		end
		return 0;
	endfunction

	function automatic logic [SAMPLE_WIDTH-1:0] mix_lane(
		input  logic signed [SAMPLE_WIDTH-1:0] xc,
		input  logic signed [SAMPLE_WIDTH-1:0] ym,
		output bit                             sat
	);
		longint x, y, a, b, s, r;
		x = xc;
		y = ym;
		a = 2 * y + x;
		b = 2 * y - x;
		s = diode_term(a) + diode_term(-a) - diode_term(b) - diode_term(-b);
		r = (s * longint'(gain_r) + (longint'(1) << 20)) >>> 21;
		sat = 1'b0;
		if (r > MAX_OUT) begin
			r = MAX_OUT;
			sat = 1'b1;
		end else if (r < MIN_OUT) begin
			r = MIN_OUT;
			sat = 1'b1;
		end
		return r[SAMPLE_WIDTH-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [W-1:0] want;
		bit           sat;
		if (!arst_n) begin
			thr_r = THR_RST;
			knee_r = KNEE_RST;
			scale_r = SCALE_RST;
			gain_r = GAIN_RST;
			mix_due.delete();
			errors = 0;
			pending = 0;
			checked = 0;
			clipped = 0;
		end else begin
			if (mix.valid && mix.ready) begin
				if (mix_due.size() == 0) begin
					errors++;
					if (errors <= PRINT_CAP)
						$display("%0t: result with no request outstanding, expected none, got %h",
							$time, mix.mixed);
				end else begin
					want = mix_due.pop_front();
					checked++;
					for (int i = 0; i < LANES; i++) begin
						if (mix.mixed[i*SAMPLE_WIDTH +: SAMPLE_WIDTH] !== want[i*SAMPLE_WIDTH +: SAMPLE_WIDTH]) begin
							errors++;
							if (errors <= PRINT_CAP)
								$display("%0t: mixed_%0d expected %0d, got %0d", $time, i,
									$signed(want[i*SAMPLE_WIDTH +: SAMPLE_WIDTH]),
									$signed(mix.mixed[i*SAMPLE_WIDTH +: SAMPLE_WIDTH]));
						end
					end
				end
			end
			if (smp.valid && smp.ready) begin
				for (int i = 0; i < LANES; i++) begin
					want[i*SAMPLE_WIDTH +: SAMPLE_WIDTH] = mix_lane(
						smp.carrier[i*SAMPLE_WIDTH +: SAMPLE_WIDTH],
						smp.modulator[i*SAMPLE_WIDTH +: SAMPLE_WIDTH], sat);
					if (sat)
						clipped++;
				end
				mix_due.push_back(want);
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_THRESHOLD: thr_r = cfg.data[THR_W-1:0];
					REG_KNEE:      knee_r = cfg.data[KNEE_W-1:0];
					REG_SCALE:     scale_r = cfg.data[SCALE_W-1:0];
					REG_GAIN:      gain_r = cfg.data[GAIN_W-1:0];
					default: ;
				endcase
			end
			pending = mix_due.size();
		end
	end

endmodule

// File: tb/sv/diode_ring_modulator_core_tb.sv
`timescale 1ns / 1ps

module diode_ring_modulator_core_tb;
	import drm_pkg::*;

	localparam int LANES       = LANES_DEF;
	localparam int SW          = SAMPLE_W_DEF;
	localparam int W           = LANES * SW;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 125;
	localparam int TAIL        = 16;
	localparam int CYCLE_LIMIT = 200000;

	localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic [SW-1:0] S_ONE = SW'(1);
	localparam logic [SW-1:0] S_KNEE = SW'(1 << 20);
	localparam logic [SW-1:0] S_HALF = SW'(1 << 19);

	logic clk = 1'b0;
	logic arst_n;
	bit   steady;
	int   n_err, n_due, n_chk, n_clip;
	int   n_sent, n_settings, n_writes, cycles;

	logic [THR_W-1:0]  cur_thr;
	logic [KNEE_W-1:0] cur_knee;

	drm_smp_if #(.LANES(LANES), .SAMPLE_WIDTH(SW)) smp ();
	drm_mix_if #(.LANES(LANES), .SAMPLE_WIDTH(SW)) mix ();
	drm_cfg_if cfg_bus ();

	diode_ring_modulator_core #(.LANES(LANES), .SAMPLE_WIDTH(SW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(smp),
		.result(mix),
		.cfg(cfg_bus)
	);

	diode_ring_modulator_core_chk #(.LANES(LANES), .SAMPLE_WIDTH(SW)) chk (
		.clk(clk),
		.arst_n(arst_n),
		.smp(smp),
		.mix(mix),
		.cfg(cfg_bus),
		.errors(n_err),
		.pending(n_due),
		.checked(n_chk),
		.clipped(n_clip)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("diode_ring_modulator_core: mismatch");
			$finish;
		end
	end

	initial begin
		mix.ready <= 1'b0;
		forever begin
			@(posedge clk);
			mix.ready <= arst_n && (steady || $urandom_range(0, 99) >= 13);
		end
	end

	task automatic send_sample(input logic [W-1:0] c, input logic [W-1:0] m);
		if (!steady && $urandom_range(0, 99) < 13) begin
			smp.valid <= 1'b0;
			@(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.carrier <= c;
		smp.modulator <= m;
		do @(posedge clk); while (!smp.ready);
		n_sent++;
	endtask

	task automatic send_same(input logic [SW-1:0] x, input logic [SW-1:0] y);
		send_sample({LANES{x}}, {LANES{y}});
	endtask

	// Hold off new requests until every outstanding result is back.
	task automatic drain();
		smp.valid <= 1'b0;
		@(posedge clk);
		while (n_due != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		n_writes++;
	endtask

	task automatic load_settings(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] knee,
		input logic [CFG_DATA_W-1:0] scale, input logic [CFG_DATA_W-1:0] gain);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_KNEE, knee);
		write_reg(REG_SCALE, scale);
		write_reg(REG_GAIN, gain);
		// Unmapped index must be dropped by the block.
		if (n_settings == 0 || $urandom_range(0, 1))
			write_reg(CFG_IDX_W'(REG_GAIN) +
				CFG_IDX_W'($urandom_range(1, (1 << CFG_IDX_W) - 1 - REG_GAIN)), $urandom());
		cfg_bus.valid <= 1'b0;
		cur_thr = thr[THR_W-1:0];
		cur_knee = knee[KNEE_W-1:0];
		n_settings++;
	endtask

	function automatic logic [SW-1:0] pick_extreme();
		case ($urandom_range(0, 6))
			0: return S_MAX;
			1: return S_MIN;
			2: return '0;
			3: return '1;
			4: return S_ONE;
			5: return {(SW/2){2'b10}};
			default: return {(SW/2){2'b01}};
		endcase
	endfunction

	function automatic void rand_lane(output logic [SW-1:0] x, output logic [SW-1:0] y);
		int sel, bend, yv;
		sel = $urandom_range(0, 99);
		if (sel < 35) begin
			x = SW'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
			y = SW'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
		end else if (sel < 65) begin
			x = SW'($urandom());
			y = SW'($urandom());
		end else if (sel < 80) begin
			x = pick_extreme();
			y = pick_extreme();
		end else begin
			// Land one drive level within three of a threshold or knee corner.
			bend = 2 * int'($urandom_range(0, 1) ? cur_thr : cur_knee);
			if ($urandom_range(0, 1))
				bend = -bend;
			yv = int'($urandom_range(0, 1 << 20)) - (1 << 19);
			x = SW'(bend - 2 * yv + int'($urandom_range(0, 6)) - 3);
			y = SW'(yv);
		end
	endfunction

	initial begin
		logic [SW-1:0] xv, yv;
		logic [W-1:0]  cv, mv;
		arst_n <= 1'b0;
		steady = 1'b0;
		smp.valid <= 1'b0;
		smp.carrier <= '0;
		smp.modulator <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= '0;
		cfg_bus.data <= '0;
		cur_thr = THR_RST;
		cur_knee = KNEE_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_same('0, '0);
		send_same(S_MAX, S_MAX);
		send_same(S_MIN, S_MIN);
		send_same(S_MAX, S_MIN);
		send_same(S_MIN, S_MAX);
		send_same('1, '1);
		send_same(S_ONE, S_ONE);
		send_same(S_ONE, '0);
		send_same('1, S_ONE);
		send_same(S_KNEE, S_HALF);
		send_same(S_KNEE + S_ONE, S_HALF);
		send_same(S_KNEE, -S_HALF);
		send_same(SW'(2), S_KNEE);
		send_same(-S_KNEE, S_KNEE + S_ONE);
		send_same({(SW/2){2'b10}}, {(SW/2){2'b01}});
		send_same({(SW/2){2'b01}}, {(SW/2){2'b10}});
		send_sample({S_MIN, S_MAX, S_ONE, SW'(0)}, {S_MAX, S_MIN, S_KNEE, S_HALF});
		send_sample({S_KNEE, -S_KNEE, S_HALF, -S_HALF}, {S_HALF, S_HALF, -S_KNEE, S_KNEE});
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: load_settings((1 << THR_W) - 1, (1 << KNEE_W) - 1, (1 << SCALE_W) - 1,
					(1 << GAIN_W) - 1);
				1: load_settings(786432, 786432, 524288, 1 << 20);
				2: load_settings(786432, 262144, 1 << 20, 3 << 20);
				3: load_settings(0, 0, 0, 0);
				4: load_settings(209715, 629146, 1310720, 1 << 20);
				5: load_settings($urandom(), $urandom(), $urandom(), $urandom());
				6: load_settings(0, 1048576, 524288000, 16777215);
				default: load_settings($urandom_range(0, 786432), $urandom_range(0, 1048576),
					$urandom_range(0, 524288000), $urandom_range(0, 4 << 20));
			endcase
			steady = (p == 4);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2 && (p == 0 || $urandom_range(0, 2) == 0))
					drain();
				for (int l = 0; l < LANES; l++) begin
					rand_lane(xv, yv);
					cv[l*SW +: SW] = xv;
					mv[l*SW +: SW] = yv;
				end
				send_sample(cv, mv);
			end
			drain();
			steady = 1'b0;
		end

		repeat (TAIL) @(posedge clk);
		$display("Ran %0d requests under %0d register settings (%0d register writes).",
			n_sent, n_settings, n_writes);
		$display("Compared %0d results, %0d lanes hit output saturation.", n_chk, n_clip);
		if (n_err == 0)
			$display("diode_ring_modulator_core: match");
		else
			$display("diode_ring_modulator_core: mismatch");
		$finish;
	end

endmodule
